[src/pdst_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdst_pkg
// shared constants and types of the per-device sequence tracker
// ----------------------------------------------------------------------------
package pdst_pkg;

   localparam int DEVICES    = 32;
   localparam int DEV_W      = 5;
   localparam int DEV_ADDR_W = (DEVICES > 1) ? $clog2(DEVICES) : 1;
   localparam int SEQ_W      = 32;
   localparam int TIME_W     = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_GAP      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_TIMEOUT = 2'd1;

   localparam logic [TIME_W-1:0] IDLE_TIMEOUT_RESET = 64'd1000000000;

   localparam logic CMD_PACKET     = 1'b0;
   localparam logic CMD_IDLE_CHECK = 1'b1;

   typedef enum logic [2:0] {
      EV_OPENED = 3'd0,
      EV_SEEN   = 3'd1,
      EV_DUP    = 3'd2,
      EV_GAP    = 3'd3,
      EV_TREG   = 3'd4,
      EV_IDLE   = 3'd5,
      EV_CLOSED = 3'd6
   } event_kind_type;

   // one session table entry as kept in the ram
   typedef struct packed {
      logic [SEQ_W-1:0]  seq;
      logic [TIME_W-1:0] stamp;
      logic [TIME_W-1:0] arrival;
   } entry_type;

endpackage
`default_nettype wire

[src/pdst_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdst channel interfaces
// request, response and register write channels with valid / ready
// ----------------------------------------------------------------------------
interface pdst_req_if;
   import pdst_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  command;
   logic [DEV_W-1:0]      device_id;
   logic [SEQ_W-1:0]      packet_sequence;
   logic [TIME_W-1:0]     packet_time;
   logic [TIME_W-1:0]     time_now;

   modport source (output valid, command, device_id, packet_sequence, packet_time,
                   time_now, input ready);
   modport sink   (input valid, command, device_id, packet_sequence, packet_time,
                   time_now, output ready);
endinterface

interface pdst_rsp_if;
   import pdst_pkg::*;
   logic                  valid;
   logic                  ready;
   event_kind_type        event_kind;
   logic [DEV_W-1:0]      event_device;
   logic [SEQ_W-1:0]      event_sequence;
   logic [SEQ_W-1:0]      next_sequence;
   logic [TIME_W-1:0]     event_time;
   logic [TIME_W-1:0]     detail;
   logic                  last_of_run;

   modport source (output valid, event_kind, event_device, event_sequence,
                   next_sequence, event_time, detail, last_of_run, input ready);
   modport sink   (input valid, event_kind, event_device, event_sequence,
                   next_sequence, event_time, detail, last_of_run, output ready);
endinterface

interface pdst_csr_if;
   import pdst_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[src/pdst_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdst_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module pdst_ram #(
   parameter int   WIDTH  = 8,
   parameter int   DEPTH  = 32,
   localparam int  ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[src/per_device_sequence_tracker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// per_device_sequence_tracker
// session table per device, sequence / timestamp checks and idle timeout sweep
// ----------------------------------------------------------------------------
// packet beat: accept with the table read, check and write back in ST_PKT,
//    then 1 to 4 result beats at one per cycle while the result channel is not stalled
// idle check beat: accept, then ST_SCAN_RD for every device and ST_SCAN_CHK for
//    each open session, plus 2 result beats per closed session; ST_SCAN_END ends
//    the sweep, with no result when nothing closes; the table has a single read port
// reset clears the valid and open bits at once and loads register defaults;
//    the ram holds no reset state and is only read behind a valid bit
// ----------------------------------------------------------------------------
module per_device_sequence_tracker (
   input wire logic    clock,
   input wire logic    reset,
   pdst_req_if.sink    req_bus,
   pdst_rsp_if.source  rsp_bus,
   pdst_csr_if.sink    csr_bus
);
   import pdst_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PKT,
      ST_PKT_EMIT,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_SCAN_EMIT,
      ST_SCAN_END
   } state_type;

   localparam logic [DEV_ADDR_W-1:0] LAST_DEV = DEV_ADDR_W'(DEVICES - 1);

   // control
   state_type              state_ff, state_in;
   logic [DEVICES-1:0]     valid_ff, valid_in;
   logic [DEVICES-1:0]     open_ff, open_in;
   logic [SEQ_W-1:0]       max_gap_ff, max_gap_in;
   logic [TIME_W-1:0]      idle_timeout_ff, idle_timeout_in;

   // captured request
   logic [DEV_ADDR_W-1:0]  pk_dev_ff, pk_dev_in;
   logic [SEQ_W-1:0]       pk_seq_ff, pk_seq_in;
   logic [TIME_W-1:0]      pk_ts_ff, pk_ts_in;
   logic [TIME_W-1:0]      now_ff, now_in;

   // pending packet events
   logic                   ev_open_ff, ev_open_in;
   logic [TIME_W-1:0]      open_detail_ff, open_detail_in;
   logic [SEQ_W-1:0]       open_exp_ff, open_exp_in;
   logic                   ev_seq_ff, ev_seq_in;
   event_kind_type         seq_kind_ff, seq_kind_in;
   logic [TIME_W-1:0]      seq_detail_ff, seq_detail_in;
   logic [SEQ_W-1:0]       seq_exp_ff, seq_exp_in;
   logic                   ev_treg_ff, ev_treg_in;
   logic [SEQ_W-1:0]       new_exp_ff, new_exp_in;

   // idle sweep
   logic [DEV_ADDR_W-1:0]  scan_ff, scan_in;
   logic [SEQ_W-1:0]       sc_seq_ff, sc_seq_in;
   logic [TIME_W-1:0]      sc_stamp_ff, sc_stamp_in;
   logic [TIME_W-1:0]      sc_idle_ff, sc_idle_in;
   // closed beat held back until we know whether it ends the run
   logic                   hold_valid_ff, hold_valid_in;
   logic [DEV_ADDR_W-1:0]  hold_dev_ff, hold_dev_in;
   logic [SEQ_W-1:0]       hold_seq_ff, hold_seq_in;
   logic [TIME_W-1:0]      hold_stamp_ff, hold_stamp_in;

   // response register
   logic                   out_valid_ff, out_valid_in;
   event_kind_type         out_kind_ff, out_kind_in;
   logic [DEV_W-1:0]       out_dev_ff, out_dev_in;
   logic [SEQ_W-1:0]       out_seq_ff, out_seq_in;
   logic [SEQ_W-1:0]       out_exp_ff, out_exp_in;
   logic [TIME_W-1:0]      out_time_ff, out_time_in;
   logic [TIME_W-1:0]      out_detail_ff, out_detail_in;
   logic                   out_last_ff, out_last_in;

   // ram port
   logic                   ram_wr_en;
   entry_type              ram_wr_data;
   logic                   ram_rd_en;
   logic [DEV_ADDR_W-1:0]  ram_rd_addr;
   logic [$bits(entry_type)-1:0] ram_rd_bits;
   entry_type              rd_entry;

   // datapath helpers
   logic                   slot_free;
   logic                   req_fire;
   logic [SEQ_W-1:0]       gap;
   logic [TIME_W-1:0]      idle_time;

   pdst_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (DEVICES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (pk_dev_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_bits)
   );

   assign rd_entry  = entry_type'(ram_rd_bits);
   assign req_fire  = req_bus.valid && req_bus.ready;
   assign slot_free = !out_valid_ff || rsp_bus.ready;
   assign gap       = pk_seq_ff - rd_entry.seq - SEQ_W'(1);
   assign idle_time = now_ff - rd_entry.arrival;

   // one item at a time: take a request beat only between items
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.event_kind     = out_kind_ff;
   assign rsp_bus.event_device   = out_dev_ff;
   assign rsp_bus.event_sequence = out_seq_ff;
   assign rsp_bus.next_sequence  = out_exp_ff;
   assign rsp_bus.event_time     = out_time_ff;
   assign rsp_bus.detail         = out_detail_ff;
   assign rsp_bus.last_of_run    = out_last_ff;

   always_comb begin
      state_in        = state_ff;
      valid_in        = valid_ff;
      open_in         = open_ff;
      max_gap_in      = max_gap_ff;
      idle_timeout_in = idle_timeout_ff;
      pk_dev_in       = pk_dev_ff;
      pk_seq_in       = pk_seq_ff;
      pk_ts_in        = pk_ts_ff;
      now_in          = now_ff;
      ev_open_in      = ev_open_ff;
      open_detail_in  = open_detail_ff;
      open_exp_in     = open_exp_ff;
      ev_seq_in       = ev_seq_ff;
      seq_kind_in     = seq_kind_ff;
      seq_detail_in   = seq_detail_ff;
      seq_exp_in      = seq_exp_ff;
      ev_treg_in      = ev_treg_ff;
      new_exp_in      = new_exp_ff;
      scan_in         = scan_ff;
      sc_seq_in       = sc_seq_ff;
      sc_stamp_in     = sc_stamp_ff;
      sc_idle_in      = sc_idle_ff;
      hold_valid_in   = hold_valid_ff;
      hold_dev_in     = hold_dev_ff;
      hold_seq_in     = hold_seq_ff;
      hold_stamp_in   = hold_stamp_ff;
      out_valid_in    = out_valid_ff && !rsp_bus.ready;
      out_kind_in     = out_kind_ff;
      out_dev_in      = out_dev_ff;
      out_seq_in      = out_seq_ff;
      out_exp_in      = out_exp_ff;
      out_time_in     = out_time_ff;
      out_detail_in   = out_detail_ff;
      out_last_in     = out_last_ff;
      ram_wr_en       = 1'b0;
      ram_wr_data     = rd_entry;
      ram_rd_en       = 1'b0;
      ram_rd_addr     = scan_ff;

      // register writes
      if (csr_bus.valid) begin
         if (csr_bus.index == CSR_MAX_GAP) begin
            max_gap_in = csr_bus.data[SEQ_W-1:0];
         end else if (csr_bus.index == CSR_IDLE_TIMEOUT) begin
            idle_timeout_in = csr_bus.data;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               pk_dev_in = req_bus.device_id[DEV_ADDR_W-1:0];
               pk_seq_in = req_bus.packet_sequence;
               pk_ts_in  = req_bus.packet_time;
               now_in    = req_bus.time_now;
               if (req_bus.command == CMD_IDLE_CHECK) begin
                  scan_in       = '0;
                  hold_valid_in = 1'b0;
                  state_in      = ST_SCAN_RD;
               end else if (32'(req_bus.device_id) < DEVICES) begin
                  // table read issued with the accept
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = req_bus.device_id[DEV_ADDR_W-1:0];
                  state_in    = ST_PKT;
               end
               // a device beyond the table is dropped without results
            end
         end

         ST_PKT: begin
            ram_wr_en           = 1'b1;
            ram_wr_data.arrival = now_ff;
            open_in[pk_dev_ff]  = 1'b1;
            ev_open_in          = !valid_ff[pk_dev_ff] || !open_ff[pk_dev_ff];
            if (!valid_ff[pk_dev_ff]) begin
               // first packet of the device: no checks
               valid_in[pk_dev_ff] = 1'b1;
               ram_wr_data.seq     = pk_seq_ff;
               ram_wr_data.stamp   = pk_ts_ff;
               open_detail_in      = '0;
               open_exp_in         = pk_seq_ff + SEQ_W'(1);
               ev_seq_in           = 1'b0;
               ev_treg_in          = 1'b0;
               new_exp_in          = pk_seq_ff + SEQ_W'(1);
            end else begin
               open_detail_in = TIME_W'(1);
               open_exp_in    = rd_entry.seq + SEQ_W'(1);
               seq_exp_in     = rd_entry.seq + SEQ_W'(1);
               new_exp_in     = rd_entry.seq + SEQ_W'(1);
               if (pk_seq_ff == rd_entry.seq) begin
                  ev_seq_in     = 1'b1;
                  seq_kind_in   = EV_DUP;
                  seq_detail_in = '0;
               end else if (pk_seq_ff > rd_entry.seq) begin
                  ev_seq_in       = (gap > max_gap_ff);
                  seq_kind_in     = EV_GAP;
                  seq_detail_in   = TIME_W'(gap);
                  ram_wr_data.seq = pk_seq_ff;
                  new_exp_in      = pk_seq_ff + SEQ_W'(1);
               end else begin
                  // late sequence
                  ev_seq_in     = 1'b1;
                  seq_kind_in   = EV_DUP;
                  seq_detail_in = TIME_W'(1);
               end
               ev_treg_in = (pk_ts_ff < rd_entry.stamp);
               if (pk_ts_ff >= rd_entry.stamp) begin
                  ram_wr_data.stamp = pk_ts_ff;
               end
            end
            state_in = ST_PKT_EMIT;
         end

         ST_PKT_EMIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_dev_in   = DEV_W'(pk_dev_ff);
               out_seq_in   = pk_seq_ff;
               out_time_in  = pk_ts_ff;
               out_last_in  = 1'b0;
               if (ev_open_ff) begin
                  ev_open_in    = 1'b0;
                  out_kind_in   = EV_OPENED;
                  out_exp_in    = open_exp_ff;
                  out_detail_in = open_detail_ff;
               end else if (ev_seq_ff) begin
                  ev_seq_in     = 1'b0;
                  out_kind_in   = seq_kind_ff;
                  out_exp_in    = seq_exp_ff;
                  out_detail_in = seq_detail_ff;
               end else if (ev_treg_ff) begin
                  ev_treg_in    = 1'b0;
                  out_kind_in   = EV_TREG;
                  out_exp_in    = new_exp_ff;
                  out_detail_in = '0;
               end else begin
                  // packet seen always closes the run
                  out_kind_in   = EV_SEEN;
                  out_exp_in    = new_exp_ff;
                  out_detail_in = '0;
                  out_last_in   = 1'b1;
                  state_in      = ST_IDLE;
               end
            end
         end

         ST_SCAN_RD: begin
            if (valid_ff[scan_ff] && open_ff[scan_ff]) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = scan_ff;
               state_in    = ST_SCAN_CHK;
            end else if (scan_ff == LAST_DEV) begin
               state_in = ST_SCAN_END;
            end else begin
               scan_in = scan_ff + DEV_ADDR_W'(1);
            end
         end

         ST_SCAN_CHK: begin
            if ((now_ff >= rd_entry.arrival) && (idle_time >= idle_timeout_ff)) begin
               open_in[scan_ff] = 1'b0;
               sc_seq_in        = rd_entry.seq;
               sc_stamp_in      = rd_entry.stamp;
               sc_idle_in       = idle_time;
               state_in         = ST_SCAN_EMIT;
            end else if (scan_ff == LAST_DEV) begin
               state_in = ST_SCAN_END;
            end else begin
               scan_in  = scan_ff + DEV_ADDR_W'(1);
               state_in = ST_SCAN_RD;
            end
         end

         ST_SCAN_EMIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_last_in  = 1'b0;
               if (hold_valid_ff) begin
                  // previous session's closed beat goes first
                  hold_valid_in = 1'b0;
                  out_kind_in   = EV_CLOSED;
                  out_dev_in    = DEV_W'(hold_dev_ff);
                  out_seq_in    = hold_seq_ff;
                  out_exp_in    = hold_seq_ff + SEQ_W'(1);
                  out_time_in   = hold_stamp_ff;
                  out_detail_in = '0;
               end else begin
                  out_kind_in   = EV_IDLE;
                  out_dev_in    = DEV_W'(scan_ff);
                  out_seq_in    = sc_seq_ff;
                  out_exp_in    = sc_seq_ff + SEQ_W'(1);
                  out_time_in   = sc_stamp_ff;
                  out_detail_in = sc_idle_ff;
                  hold_valid_in = 1'b1;
                  hold_dev_in   = scan_ff;
                  hold_seq_in   = sc_seq_ff;
                  hold_stamp_in = sc_stamp_ff;
                  if (scan_ff == LAST_DEV) begin
                     state_in = ST_SCAN_END;
                  end else begin
                     scan_in  = scan_ff + DEV_ADDR_W'(1);
                     state_in = ST_SCAN_RD;
                  end
               end
            end
         end

         ST_SCAN_END: begin
            if (!hold_valid_ff) begin
               // nothing closed: no results
               state_in = ST_IDLE;
            end else if (slot_free) begin
               hold_valid_in = 1'b0;
               out_valid_in  = 1'b1;
               out_kind_in   = EV_CLOSED;
               out_dev_in    = DEV_W'(hold_dev_ff);
               out_seq_in    = hold_seq_ff;
               out_exp_in    = hold_seq_ff + SEQ_W'(1);
               out_time_in   = hold_stamp_ff;
               out_detail_in = '0;
               out_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         valid_ff        <= '0;
         open_ff         <= '0;
         max_gap_ff      <= '0;
         idle_timeout_ff <= IDLE_TIMEOUT_RESET;
         hold_valid_ff   <= 1'b0;
         out_valid_ff    <= 1'b0;
         ev_open_ff      <= 1'b0;
         ev_seq_ff       <= 1'b0;
         ev_treg_ff      <= 1'b0;
      end else begin
         state_ff        <= state_in;
         valid_ff        <= valid_in;
         open_ff         <= open_in;
         max_gap_ff      <= max_gap_in;
         idle_timeout_ff <= idle_timeout_in;
         hold_valid_ff   <= hold_valid_in;
         out_valid_ff    <= out_valid_in;
         ev_open_ff      <= ev_open_in;
         ev_seq_ff       <= ev_seq_in;
         ev_treg_ff      <= ev_treg_in;
      end
      pk_dev_ff      <= pk_dev_in;
      pk_seq_ff      <= pk_seq_in;
      pk_ts_ff       <= pk_ts_in;
      now_ff         <= now_in;
      open_detail_ff <= open_detail_in;
      open_exp_ff    <= open_exp_in;
      seq_kind_ff    <= seq_kind_in;
      seq_detail_ff  <= seq_detail_in;
      seq_exp_ff     <= seq_exp_in;
      new_exp_ff     <= new_exp_in;
      scan_ff        <= scan_in;
      sc_seq_ff      <= sc_seq_in;
      sc_stamp_ff    <= sc_stamp_in;
      sc_idle_ff     <= sc_idle_in;
      hold_dev_ff    <= hold_dev_in;
      hold_seq_ff    <= hold_seq_in;
      hold_stamp_ff  <= hold_stamp_in;
      out_kind_ff    <= out_kind_in;
      out_dev_ff     <= out_dev_in;
      out_seq_ff     <= out_seq_in;
      out_exp_ff     <= out_exp_in;
      out_time_ff    <= out_time_in;
      out_detail_ff  <= out_detail_in;
      out_last_ff    <= out_last_in;
   end

endmodule
`default_nettype wire

[src/pdst_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdst_checker
// port level checks of the response stream of the sequence tracker
// ----------------------------------------------------------------------------
module pdst_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire pdst_pkg::event_kind_type      rsp_kind,
   input wire logic [pdst_pkg::DEV_W-1:0]    rsp_device,
   input wire logic [pdst_pkg::SEQ_W-1:0]    rsp_sequence,
   input wire logic [pdst_pkg::SEQ_W-1:0]    rsp_expected,
   input wire logic                          rsp_last
);
   import pdst_pkg::*;

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_device) && $stable(rsp_last))
      else $error("response beat changed while stalled");

   // packet seen and nothing else can end a packet run; idle never ends a run
   a_seen_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == EV_SEEN) |-> rsp_last)
      else $error("packet seen beat without end of run");

   a_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == EV_OPENED || rsp_kind == EV_DUP || rsp_kind == EV_GAP
         || rsp_kind == EV_TREG || rsp_kind == EV_IDLE) |-> !rsp_last)
      else $error("run ended on a beat that is always followed by another");

   // the sequence tracker takes no new request before a run has been handed over
   a_no_req_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !(req_valid && req_ready))
      else $error("request taken in the middle of a result run");

   // expected sequence of an idle or closed beat follows its sequence
   a_idle_expected: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == EV_IDLE || rsp_kind == EV_CLOSED)
         |-> rsp_expected == rsp_sequence + SEQ_W'(1))
      else $error("idle or closed beat with wrong expected sequence");

endmodule

bind per_device_sequence_tracker pdst_checker u_pdst_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_kind     (rsp_bus.event_kind),
   .rsp_device   (rsp_bus.event_device),
   .rsp_sequence (rsp_bus.event_sequence),
   .rsp_expected (rsp_bus.next_sequence),
   .rsp_last     (rsp_bus.last_of_run)
);
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the per-device sequence tracker: directed and random
// packet and idle-check beats, a session-table predictor and an in-order check
// of every result beat, with random stalls on the request and result channels
// ----------------------------------------------------------------------------
module tb_top;
   import pdst_pkg::*;

   // one request beat as queued for the driver
   typedef struct {
      logic              command;
      logic [DEV_W-1:0]  device_id;
      logic [SEQ_W-1:0]  packet_sequence;
      logic [TIME_W-1:0] packet_time;
      logic [TIME_W-1:0] time_now;
   } tracker_req_type;

   // one predicted result beat
   typedef struct {
      event_kind_type    kind;
      logic [DEV_W-1:0]  device;
      logic [SEQ_W-1:0]  seq_no;
      logic [SEQ_W-1:0]  next_seq;
      logic [TIME_W-1:0] stamp;
      logic [TIME_W-1:0] detail;
      logic              last;
   } tracker_event_type;

   logic clock;
   logic reset;

   pdst_req_if req_bus ();
   pdst_rsp_if rsp_bus ();
   pdst_csr_if csr_bus ();

   per_device_sequence_tracker dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // request beats waiting for the driver, and result beats still owed
   tracker_req_type   pending_reqs[$];
   tracker_event_type expected_events[$];
   tracker_req_type   cur_req;

   // shadow session table and register copies
   bit                sess_valid[DEVICES];
   bit                sess_open[DEVICES];
   logic [SEQ_W-1:0]  sess_seq[DEVICES];
   logic [TIME_W-1:0] sess_stamp[DEVICES];
   logic [TIME_W-1:0] sess_arrival[DEVICES];
   logic [SEQ_W-1:0]  max_gap_q      = '0;
   logic [TIME_W-1:0] idle_timeout_q = IDLE_TIMEOUT_RESET;

   // stimulus side: running wall clock and last sequence handed out per device
   logic [TIME_W-1:0] clock_ns = 64'd1_000_000;
   logic [SEQ_W-1:0]  gen_seq[DEVICES];

   bit steady;        // set during the stretch with no stalls at all
   int failures;
   int beats_checked;
   int packets_sent;
   int checks_sent;
   int csr_writes;
   int kind_seen[7];

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // roughly 19 calls in a hundred ask for a stall, unless in the calm stretch
   function automatic bit take_break();
      return !steady && ($urandom_range(99) < 19);
   endfunction

   // ---------------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------------

   // expected-next sequence is taken from the table at the time of the event
   function automatic void push_event(event_kind_type kind, int dev, logic [SEQ_W-1:0] seq,
                                      logic [TIME_W-1:0] stamp, logic [TIME_W-1:0] detail);
      tracker_event_type ev;
      ev.kind     = kind;
      ev.device   = DEV_W'(dev);
      ev.seq_no   = seq;
      ev.next_seq = sess_seq[dev] + 1'b1;
      ev.stamp    = stamp;
      ev.detail   = detail;
      ev.last     = 1'b0;
      expected_events.insert(expected_events.size(), ev);
   endfunction

   function automatic void predict_events(tracker_req_type r);
      int                first;
      int                d;
      logic [SEQ_W-1:0]  gap;
      logic [TIME_W-1:0] idle;
      first = expected_events.size();
      d     = r.device_id;
      if (r.command == CMD_PACKET) begin
         packets_sent++;
         if (d < DEVICES) begin
            if (!sess_valid[d]) begin
               // first packet of a device: open without any checks
               sess_valid[d]   = 1'b1;
               sess_open[d]    = 1'b1;
               sess_seq[d]     = r.packet_sequence;
               sess_stamp[d]   = r.packet_time;
               sess_arrival[d] = r.time_now;
               push_event(EV_OPENED, d, r.packet_sequence, r.packet_time, 64'd0);
               push_event(EV_SEEN, d, r.packet_sequence, r.packet_time, 64'd0);
            end else begin
               if (!sess_open[d]) begin
                  sess_open[d] = 1'b1;
                  push_event(EV_OPENED, d, r.packet_sequence, r.packet_time, 64'd1);
               end
               // plain unsigned compare, no serial-number wrap
               if (r.packet_sequence == sess_seq[d]) begin
                  push_event(EV_DUP, d, r.packet_sequence, r.packet_time, 64'd0);
               end else if (r.packet_sequence > sess_seq[d]) begin
                  gap = r.packet_sequence - sess_seq[d] - 1'b1;
                  if (gap > max_gap_q)
                     push_event(EV_GAP, d, r.packet_sequence, r.packet_time, TIME_W'(gap));
                  sess_seq[d] = r.packet_sequence;
               end else begin
                  push_event(EV_DUP, d, r.packet_sequence, r.packet_time, 64'd1);
               end
               // a stamp that goes back leaves the stored one in place
               if (r.packet_time < sess_stamp[d])
                  push_event(EV_TREG, d, r.packet_sequence, r.packet_time, 64'd0);
               else
                  sess_stamp[d] = r.packet_time;
               sess_arrival[d] = r.time_now;
               push_event(EV_SEEN, d, r.packet_sequence, r.packet_time, 64'd0);
            end
         end
      end else begin
         checks_sent++;
         // ascending sweep; sessions with an arrival in the future are skipped
         for (int k = 0; k < DEVICES; k++) begin
            if (sess_valid[k] && sess_open[k] && r.time_now >= sess_arrival[k]) begin
               idle = r.time_now - sess_arrival[k];
               if (idle >= idle_timeout_q) begin
                  sess_open[k] = 1'b0;
                  push_event(EV_IDLE, k, sess_seq[k], sess_stamp[k], idle);
                  push_event(EV_CLOSED, k, sess_seq[k], sess_stamp[k], 64'd0);
               end
            end
         end
      end
      if (expected_events.size() > first)
         expected_events[expected_events.size() - 1].last = 1'b1;
   endfunction

   // ---------------------------------------------------------------------------
   // request driver: predicts each beat at the edge where it is taken
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : req_driver
      bit fire;
      fire = !reset && req_bus.valid && req_bus.ready;
      if (fire)
         predict_events(cur_req);
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (fire || !req_bus.valid) begin
         if (pending_reqs.size() != 0 && !take_break()) begin
            cur_req = pending_reqs.pop_front();
            req_bus.valid           <= 1'b1;
            req_bus.command         <= cur_req.command;
            req_bus.device_id       <= cur_req.device_id;
            req_bus.packet_sequence <= cur_req.packet_sequence;
            req_bus.packet_time     <= cur_req.packet_time;
            req_bus.time_now        <= cur_req.time_now;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // result monitor: every beat against the oldest expectation
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      tracker_event_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_events.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("[%0t] result beat with nothing expected: kind %0d device %0d",
                        $realtime, rsp_bus.event_kind, rsp_bus.event_device);
         end else begin
            want = expected_events.pop_front();
            beats_checked++;
            kind_seen[int'(want.kind)]++;
            if (rsp_bus.event_kind     !== want.kind     ||
                rsp_bus.event_device   !== want.device   ||
                rsp_bus.event_sequence !== want.seq_no   ||
                rsp_bus.next_sequence  !== want.next_seq ||
                rsp_bus.event_time     !== want.stamp    ||
                rsp_bus.detail         !== want.detail   ||
                rsp_bus.last_of_run    !== want.last) begin
               failures++;
               if (failures <= 10) begin
                  $display({"[%0t] mismatch, expected kind %0d dev %0d seq %h next %h",
                            " time %h detail %h last %b"},
                           $realtime, want.kind, want.device, want.seq_no, want.next_seq,
                           want.stamp, want.detail, want.last);
                  $display({"[%0t]           actual kind %0d dev %0d seq %h next %h",
                            " time %h detail %h last %b"},
                           $realtime, rsp_bus.event_kind, rsp_bus.event_device,
                           rsp_bus.event_sequence, rsp_bus.next_sequence,
                           rsp_bus.event_time, rsp_bus.detail, rsp_bus.last_of_run);
               end
            end
         end
      end
      rsp_bus.ready <= !reset && !take_break();
   end

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------
   function automatic void push_req(logic cmd, int dev, logic [SEQ_W-1:0] seq,
                                    logic [TIME_W-1:0] stamp, logic [TIME_W-1:0] now);
      tracker_req_type r;
      r.command         = cmd;
      r.device_id       = DEV_W'(dev);
      r.packet_sequence = seq;
      r.packet_time     = stamp;
      r.time_now        = now;
      pending_reqs.insert(pending_reqs.size(), r);
   endfunction

   // register write beat; the shadow copy follows once the beat is taken
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      if (idx == CSR_MAX_GAP)
         max_gap_q = value[SEQ_W-1:0];
      else if (idx == CSR_IDLE_TIMEOUT)
         idle_timeout_q = value;
      csr_writes++;
      @(negedge clock);
   endtask

   // drain everything, then allow for an idle sweep that produces no beats
   task automatic wait_quiet();
      while (pending_reqs.size() != 0 || req_bus.valid || expected_events.size() != 0)
         @(negedge clock);
      repeat (150) @(negedge clock);
   endtask

   // mostly well-formed per-device traffic over a few busy devices, some idle
   // sweeps that either do or do not cross the timeout, and a share of noise
   task automatic add_random_run(int count);
      int                roll;
      int                d;
      logic [SEQ_W-1:0]  s;
      logic [TIME_W-1:0] ts;
      for (int k = 0; k < count; k++) begin
         roll = $urandom_range(99);
         if (roll < 10) begin
            // noise: every field over its full range
            push_req($urandom_range(3) == 0, $urandom_range(31), $urandom,
                     {$urandom, $urandom},
                     $urandom_range(1) ? {$urandom, $urandom} : clock_ns);
         end else if (roll < 22) begin
            if ($urandom_range(1))
               clock_ns += idle_timeout_q + $urandom_range(0, 2000);
            else
               clock_ns += $urandom_range(0, 30000);
            push_req(CMD_IDLE_CHECK, $urandom_range(31), $urandom, {$urandom, $urandom},
                     clock_ns);
         end else begin
            d    = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(5);
            roll = $urandom_range(99);
            if (roll < 65)
               s = gen_seq[d] + 1'b1;
            else if (roll < 75)
               s = gen_seq[d];
            else if (roll < 85)
               s = gen_seq[d] + $urandom_range(2, 8);
            else if (roll < 93)
               s = gen_seq[d] - $urandom_range(1, 4);
            else
               s = $urandom;
            if (s > gen_seq[d])
               gen_seq[d] = s;
            clock_ns += $urandom_range(1, 20000);
            // occasionally a stamp well behind the device's recent ones
            if ($urandom_range(99) < 8)
               ts = clock_ns - $urandom_range(200000, 2000000);
            else
               ts = clock_ns - $urandom_range(0, 100);
            push_req(CMD_PACKET, d, s, ts, clock_ns);
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      req_bus.valid           = 1'b0;
      req_bus.command         = CMD_PACKET;
      req_bus.device_id       = '0;
      req_bus.packet_sequence = '0;
      req_bus.packet_time     = '0;
      req_bus.time_now        = '0;
      rsp_bus.ready           = 1'b0;
      csr_bus.valid           = 1'b0;
      csr_bus.index           = CSR_MAX_GAP;
      csr_bus.data            = '0;
      steady                  = 1'b0;
      for (int k = 0; k < DEVICES; k++)
         gen_seq[k] = $urandom_range(0, 1000);
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // register defaults: max gap 0, timeout one second
      push_req(CMD_PACKET, 0, 32'd100, 64'd1000, 64'd1000);      // new session
      push_req(CMD_PACKET, 0, 32'd101, 64'd2000, 64'd2000);      // in order
      push_req(CMD_PACKET, 0, 32'd101, 64'd3000, 64'd3000);      // duplicate, equal
      push_req(CMD_PACKET, 0, 32'd50, 64'd4000, 64'd4000);       // duplicate, older
      push_req(CMD_PACKET, 0, 32'd105, 64'd5000, 64'd5000);      // gap of three
      push_req(CMD_PACKET, 0, 32'd106, 64'd500, 64'd6000);       // stamp goes back
      push_req(CMD_PACKET, 31, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'd7000);
      push_req(CMD_PACKET, 31, 32'd0, 64'd0, 64'd8000);          // no wrap handling
      push_req(CMD_PACKET, 1, 32'd0, 64'd0, 64'd0);
      push_req(CMD_IDLE_CHECK, 0, 32'd0, 64'd0, 64'd500);        // nothing to close
      push_req(CMD_IDLE_CHECK, 21, 32'd0, 64'd0, 64'd1_000_000_000); // idle exactly timeout
      push_req(CMD_IDLE_CHECK, 10, 32'd0, 64'd0, 64'd2_000_000_000);
      push_req(CMD_PACKET, 0, 32'd107, 64'd2_000_000_000, 64'd2_000_000_000); // reopen
      push_req(CMD_PACKET, 10, 32'd0, 64'd0, 64'd2_000_000_000);
      push_req(CMD_IDLE_CHECK, 31, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
               64'hFFFF_FFFF_FFFF_FFFF);
      wait_quiet();

      // widest gap allowed, zero timeout
      write_csr(CSR_MAX_GAP, 64'hFFFF_FFFF);
      write_csr(CSR_IDLE_TIMEOUT, 64'd0);
      push_req(CMD_PACKET, 2, 32'd0, 64'd10, 64'd100);
      push_req(CMD_PACKET, 2, 32'hFFFF_FFFF, 64'd20, 64'd200);   // huge gap, no event
      push_req(CMD_PACKET, 0, 32'd500, 64'd30, 64'd300);         // reopen plus stamp back
      push_req(CMD_IDLE_CHECK, 0, 32'd0, 64'd0, 64'd250);        // device 0 arrived later
      push_req(CMD_IDLE_CHECK, 0, 32'd0, 64'd0, 64'd300);        // zero idle still closes
      wait_quiet();

      // largest timeout, gap threshold of one
      write_csr(CSR_IDLE_TIMEOUT, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(CSR_MAX_GAP, 64'd1);
      push_req(CMD_PACKET, 5, 32'd7, 64'd7, 64'd0);
      push_req(CMD_PACKET, 5, 32'd10, 64'd8, 64'd0);             // gap two, reported
      push_req(CMD_PACKET, 5, 32'd12, 64'd9, 64'd0);             // gap one, silent
      push_req(CMD_IDLE_CHECK, 0, 32'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      wait_quiet();

      // random traffic under several settings
      clock_ns = 64'd3_000_000_000;
      write_csr(CSR_MAX_GAP, 64'd2);
      write_csr(CSR_IDLE_TIMEOUT, IDLE_TIMEOUT_RESET);
      add_random_run(52);
      wait_quiet();

      steady = 1'b1;
      write_csr(CSR_MAX_GAP, 64'd0);
      write_csr(CSR_IDLE_TIMEOUT, 64'd50000);
      add_random_run(52);
      wait_quiet();
      steady = 1'b0;

      write_csr(CSR_MAX_GAP, $urandom_range(0, 6));
      write_csr(CSR_IDLE_TIMEOUT, $urandom_range(20000, 400000));
      add_random_run(52);
      wait_quiet();

      write_csr(CSR_MAX_GAP, $urandom_range(0, 3));
      write_csr(CSR_IDLE_TIMEOUT, 64'd5_000_000);
      add_random_run(52);
      wait_quiet();

      $display("run covered %0d packet beats and %0d idle sweeps under %0d register writes",
               packets_sent, checks_sent, csr_writes);
      $display({"checked %0d result beats: opened %0d seen %0d dup %0d gap %0d",
                " treg %0d idle %0d closed %0d"},
               beats_checked, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3],
               kind_seen[4], kind_seen[5], kind_seen[6]);
      if (failures == 0 && expected_events.size() == 0) begin
         $display("PASS");
      end else begin
         $display("%0d failures, %0d result beats never arrived", failures,
                  expected_events.size());
         $display("FAIL");
      end
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin : watchdog
      #6_000_000;
      $display("timeout with %0d result beats outstanding", expected_events.size());
      $display("FAIL");
      $finish;
   end

endmodule

[files.f]
src/pdst_pkg.sv
src/pdst_if.sv
src/pdst_ram.sv
src/per_device_sequence_tracker.sv
src/pdst_checker.sv
tb/tb_top.sv
